@@ hw/rtl/spi_pkg.sv @@
// ---------------------------------------------------------------------------
// spi_pkg: shared types and constants for the signature peak interval block
// Widths of the word fields, parameter defaults, controller states and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

  localparam int MAX_LENGTH_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 7;
  localparam int INTERVAL_W = 16;

  localparam logic [COUNT_W-1:0]    PEAK_COUNT_MAX = 7'd127;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    SLOPE_FLAT,
    SLOPE_RISE,
    SLOPE_FALL
  } slope_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;    // take one sample word
    logic start;     // last sample: load divider, clear the run
    logic div_step;  // one quotient bit
    logic load_out;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/spi_if.sv @@
// ---------------------------------------------------------------------------
// spi_in_if / spi_out_if: valid/ready channels of the peak interval block
// The input channel moves one sample word, the output channel one result.
// ---------------------------------------------------------------------------
`default_nettype none

interface spi_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [spi_pkg::SAMPLE_W-1:0] sample;
  logic                                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface spi_out_if;
  logic                              valid;
  logic                              ready;
  logic [spi_pkg::INTERVAL_W-1:0]    peak_interval;
  logic                              interval_valid;
  logic [spi_pkg::COUNT_W-1:0]       peak_count;

  modport source (output valid, output peak_interval, output interval_valid,
                  output peak_count, input ready);
  modport sink   (input valid, input peak_interval, input interval_valid,
                  input peak_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/spi_ctrl.sv @@
// ---------------------------------------------------------------------------
// spi_ctrl: controller of the signature peak interval block
// Sequences sample intake, the serial divide after the last sample and the
// hand-off into the output register; owns in_ready and out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire spi_pkg::sts_t sts,
  output spi_pkg::cmd_t      cmd
);

  spi_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spi_pkg::ST_RUN: begin
        if (in_valid && in_last) state_nxt = spi_pkg::ST_DIV;
      end
      spi_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = spi_pkg::ST_DONE;
      end
      spi_pkg::ST_DONE: begin
        if (out_free) state_nxt = spi_pkg::ST_RUN;
      end
      default: state_nxt = spi_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      spi_pkg::ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.start  = in_valid && in_last;
      end
      spi_pkg::ST_DIV: begin
        cmd.div_step = !sts.div_done;
      end
      spi_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spi_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/spi_datapath.sv @@
// ---------------------------------------------------------------------------
// spi_datapath: datapath of the signature peak interval block
// Slope and peak detection per sample, peak count and positions, a restoring
// divider one quotient bit per cycle, and the output payload register.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_datapath #(
  parameter int MAX_LENGTH    = spi_pkg::MAX_LENGTH_DEF,
  parameter int FRACTION_BITS = spi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire spi_pkg::cmd_t                       cmd,
  output spi_pkg::sts_t                            sts,
  input  wire logic signed [spi_pkg::SAMPLE_W-1:0] in_sample,
  output logic [spi_pkg::INTERVAL_W-1:0]           peak_interval,
  output logic                                     interval_valid,
  output logic [spi_pkg::COUNT_W-1:0]              peak_count
);

  localparam int IDX_W  = $clog2(MAX_LENGTH);
  localparam int DIV_W  = IDX_W + FRACTION_BITS;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int CW     = spi_pkg::COUNT_W;
  localparam int EXT_W  = DIV_W + spi_pkg::INTERVAL_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LENGTH - 1);

  // run state
  logic signed [spi_pkg::SAMPLE_W-1:0] prev_sample_r;
  spi_pkg::slope_t                     prev_slope_r, slope;
  logic [IDX_W-1:0]                    idx_r;
  logic [CW-1:0]                       total_r, total_nxt;
  logic [IDX_W-1:0]                    first_r, first_nxt, last_r, last_nxt;
  logic [IDX_W-1:0]                    pos;
  logic                                peak;

  // divider
  logic [DIV_W-1:0] dvd_r;
  logic [CW-1:0]    rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    hold_count_r;
  logic             hold_ok_r;
  logic [CW:0]      rem_sh;
  logic [CW+1:0]    diff;
  logic [EXT_W-1:0] quo_ext;

  // output payload
  logic [spi_pkg::INTERVAL_W-1:0] out_interval_r;
  logic                           out_ok_r;
  logic [CW-1:0]                  out_count_r;

  always_comb begin
    if (in_sample > prev_sample_r)      slope = spi_pkg::SLOPE_RISE;
    else if (in_sample < prev_sample_r) slope = spi_pkg::SLOPE_FALL;
    else                                slope = spi_pkg::SLOPE_FLAT;
    peak = (idx_r >= IDX_W'(2)) && (prev_slope_r == spi_pkg::SLOPE_RISE)
           && (slope == spi_pkg::SLOPE_FALL);
    pos       = idx_r - IDX_W'(2);
    first_nxt = (peak && total_r == '0) ? pos : first_r;
    last_nxt  = peak ? pos : last_r;
    total_nxt = (peak && total_r != spi_pkg::PEAK_COUNT_MAX) ? total_r + CW'(1) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_slope_r  <= spi_pkg::SLOPE_FLAT;
      idx_r         <= '0;
      total_r       <= '0;
      first_r       <= '0;
      last_r        <= '0;
    end else if (cmd.start) begin
      // end of run: back to the reset state
      prev_sample_r <= '0;
      prev_slope_r  <= spi_pkg::SLOPE_FLAT;
      idx_r         <= '0;
      total_r       <= '0;
      first_r       <= '0;
      last_r        <= '0;
    end else if (cmd.accept) begin
      prev_sample_r <= in_sample;
      if (idx_r != '0) prev_slope_r <= slope;
      if (idx_r != IDX_LAST) idx_r <= idx_r + IDX_W'(1);
      total_r <= total_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  // restoring divide: shift in one dividend bit, subtract when it fits
  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r        <= DIV_W'(last_nxt - first_nxt) << FRACTION_BITS;
      rem_r        <= '0;
      dvs_r        <= total_nxt - CW'(1);
      hold_count_r <= total_nxt;
      hold_ok_r    <= total_nxt >= CW'(2);
    end else if (cmd.div_step) begin
      if (!diff[CW+1]) begin
        rem_r <= diff[CW-1:0];
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CW-1:0];
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign sts.div_done = (cnt_r == '0);
  assign quo_ext      = EXT_W'(dvd_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r    <= hold_ok_r;
      out_count_r <= hold_count_r;
      if (!hold_ok_r)
        out_interval_r <= '0;
      else if (quo_ext > EXT_W'(spi_pkg::INTERVAL_MAX))
        out_interval_r <= spi_pkg::INTERVAL_MAX;
      else
        out_interval_r <= quo_ext[spi_pkg::INTERVAL_W-1:0];
    end
  end

  assign peak_interval  = out_interval_r;
  assign interval_valid = out_ok_r;
  assign peak_count     = out_count_r;

endmodule

`default_nettype wire

@@ hw/rtl/signature_peak_interval.sv @@
// ---------------------------------------------------------------------------
// signature_peak_interval: mean peak spacing of a run of signature samples
// Input channel: one signed 16-bit sample per word, last_sample closes a run.
// Output channel: one result word per run: peak_interval (unsigned, with
// FRACTION_BITS fraction bits, Q8.8 by default), interval_valid (two or more
// peaks) and peak_count (saturating at 127).
// Samples are taken one per cycle while in_ready is high. The last sample of a run
// starts a restoring divider that yields one quotient bit per cycle; once it
// is through, the result word is moved into the output register and
// out_valid rises. in_ready is low while the divider runs and until the
// result word has been moved into the output register.
// The result sits in an output register: the next run is taken while it
// waits. If the receiver still holds off when the next run's result is done,
// intake stops until the output register frees up.
// Reset (synchronous, active low) clears the run state and empties the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module signature_peak_interval #(
  parameter int MAX_LENGTH    = spi_pkg::MAX_LENGTH_DEF,
  parameter int FRACTION_BITS = spi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spi_in_if.sink     in_if,
  spi_out_if.source  out_if
);

  spi_pkg::cmd_t cmd;
  spi_pkg::sts_t sts;

  spi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last_sample),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  spi_datapath #(
    .MAX_LENGTH    (MAX_LENGTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_if.sample),
    .peak_interval  (out_if.peak_interval),
    .interval_valid (out_if.interval_valid),
    .peak_count     (out_if.peak_count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/spi_checker.sv @@
// ---------------------------------------------------------------------------
// spi_checker: port-level checks for the signature peak interval block
// Output handshake, result consistency and intake stop after a last sample.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_last,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [spi_pkg::INTERVAL_W-1:0] out_interval,
  input wire logic                           out_ok,
  input wire logic [spi_pkg::COUNT_W-1:0]    out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_interval) && $stable(out_ok)
                                && $stable(out_count))
    else $error("result word changed while stalled");

  a_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_interval == '0)
    else $error("interval nonzero without two peaks");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ok == (out_count >= spi_pkg::COUNT_W'(2)))
    else $error("interval_valid disagrees with peak_count");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken while divider runs");

endmodule

bind signature_peak_interval spi_checker u_spi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_last      (in_if.last_sample),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_interval (out_if.peak_interval),
  .out_ok       (out_if.interval_valid),
  .out_count    (out_if.peak_count)
);

`default_nettype wire
